// ===== rtl/htn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the height-to-normal-map block.
// Used by htn_norm and height_to_normal_map; depends on nothing.
package htn_pkg;

    localparam int MAX_SIZE = 512;
    localparam int COL_W    = $clog2(MAX_SIZE);
    localparam int SIZE_W   = 10;
    localparam int PIX_W    = 16;
    localparam int STR_W    = 12;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 12;
    localparam int IDX_W    = 2;

    // Arithmetic widths of the normalizer
    localparam int PROD_W   = 30;   // signed gradient times strength
    localparam int MAG_W    = 28;   // magnitude of that product
    localparam int HALF_W   = 14;
    localparam int ROOT_W   = 29;   // floor of the vector length
    localparam int SQ_W     = 59;   // sum of squares
    localparam int NUM_W    = 39;   // dividend of the byte conversion
    localparam int QUO_W    = 9;
    localparam int DCNT_W   = 4;

    localparam logic [23:0]       UNIT_SCALE = 24'd16776960;
    localparam logic [SQ_W-1:0]   UNIT_SQ    = SQ_W'(64'd281466386841600);
    localparam logic [NUM_W-1:0]  HB_BIAS    = NUM_W'(257);
    localparam logic [NUM_W-1:0]  HB_DIV     = NUM_W'(514);

    localparam logic [SIZE_W-1:0] WIDTH_RST    = SIZE_W'(512);
    localparam logic [SIZE_W-1:0] HEIGHT_RST   = SIZE_W'(512);
    localparam logic [STR_W-1:0]  STRENGTH_RST = STR_W'(1152);

    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH    = 2'd0,
        REG_HEIGHT   = 2'd1,
        REG_STRENGTH = 2'd2
    } htn_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] down;
        logic [PIX_W-1:0] center;
    } htn_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] hbyte;
    } htn_rsp_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
        htn_req_t         nbr;
        logic             run_last;
        logic             frame_done;
    } htn_slot_t;

    typedef enum logic [2:0] {
        N_IDLE, N_MUL, N_SQR, N_ROOT, N_LOAD, N_DIV, N_DONE
    } htn_nstate_t;

    typedef enum logic [2:0] {
        T_IDLE, T_RD0, T_RD1, T_RD2, T_WB, T_EMIT, T_CALC, T_OUT
    } htn_tstate_t;

endpackage

// ===== rtl/htn_norm.sv =====
`timescale 1ns / 1ps
// Normalizer: scales central differences, takes the vector length with a
// bit-serial square root and turns each component into a byte. Uses htn_pkg.
module htn_norm (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  htn_pkg::htn_req_t       req,
    input  logic [htn_pkg::STR_W-1:0] strength,
    output logic                    done,
    output htn_pkg::htn_rsp_t       rsp
);
    import htn_pkg::*;

    htn_nstate_t state_reg, state_next;

    logic signed [PROD_W-1:0] x_reg, y_reg;
    logic [SQ_W-1:0]          acc_reg, rem_reg, root_reg, bit_reg;
    logic [1:0]               sq_cnt_reg, comp_reg;
    logic [DCNT_W-1:0]        div_cnt_reg;
    logic [NUM_W-1:0]         num_reg, den_reg;
    logic [QUO_W-1:0]         quo_reg;
    htn_rsp_t                 rsp_reg;

    logic signed [PIX_W:0]    dx, dy;
    logic signed [PROD_W-1:0] mul_x, mul_y, s_ext;
    logic [MAG_W-1:0]         mag_x, mag_y, sq_a;
    logic [HALF_W-1:0]        sq_b;
    logic [MAG_W+HALF_W-1:0]  sq_prod;
    logic [SQ_W-1:0]          sq_term, trial;
    logic                     root_ge;
    logic [ROOT_W-1:0]        len;
    logic signed [PROD_W:0]   nr;
    logic [PROD_W-1:0]        t_sum;
    logic [NUM_W-1:0]         num_load, den_load;
    logic                     div_ge;
    logic [QUO_W-1:0]         q_new;
    logic [BYTE_W-1:0]        q_byte;

    // Scale the differences
    assign dx    = $signed({1'b0, req.right}) - $signed({1'b0, req.left});
    assign dy    = $signed({1'b0, req.down}) - $signed({1'b0, req.up});
    assign s_ext = PROD_W'($signed({1'b0, strength}));
    assign mul_x = PROD_W'(dx) * s_ext;
    assign mul_y = PROD_W'(dy) * s_ext;

    // Square by halves: one 28 x 14 product a cycle
    assign mag_x   = x_reg[PROD_W-1] ? MAG_W'(-x_reg) : MAG_W'(x_reg);
    assign mag_y   = y_reg[PROD_W-1] ? MAG_W'(-y_reg) : MAG_W'(y_reg);
    assign sq_a    = sq_cnt_reg[1] ? mag_y : mag_x;
    assign sq_b    = sq_cnt_reg[0] ? sq_a[MAG_W-1:HALF_W] : sq_a[HALF_W-1:0];
    assign sq_prod = (MAG_W+HALF_W)'(sq_a) * (MAG_W+HALF_W)'(sq_b);
    assign sq_term = sq_cnt_reg[0] ? SQ_W'({sq_prod, {HALF_W{1'b0}}}) : SQ_W'(sq_prod);

    // One root bit a cycle
    assign trial   = root_reg + bit_reg;
    assign root_ge = rem_reg >= trial;
    assign len     = root_reg[ROOT_W-1:0];

    // Byte conversion operands: floor((255 * (N + R) + R) / 2R)
    always_comb
    begin
        unique case (comp_reg)
            2'd0:    nr = $signed({2'b00, len}) - (PROD_W+1)'(x_reg);
            2'd1:    nr = $signed({2'b00, len}) - (PROD_W+1)'(y_reg);
            default: nr = $signed({2'b00, len}) + $signed((PROD_W+1)'(UNIT_SCALE));
        endcase
        t_sum = nr[PROD_W-1:0];
        if (comp_reg == 2'd3)
        begin
            num_load = NUM_W'({req.center, 1'b0}) + HB_BIAS;
            den_load = HB_DIV << (QUO_W - 1);
        end
        else
        begin
            num_load = (NUM_W'(t_sum) << 8) - NUM_W'(t_sum) + NUM_W'(len);
            den_load = NUM_W'({len, 1'b0}) << (QUO_W - 1);
        end
    end

    assign div_ge = num_reg >= den_reg;
    assign q_new  = {quo_reg[QUO_W-2:0], div_ge};
    assign q_byte = q_new[QUO_W-1] ? {BYTE_W{1'b1}} : q_new[BYTE_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE: if (start) state_next = N_MUL;
            N_MUL:  state_next = N_SQR;
            N_SQR:  if (sq_cnt_reg == 2'd3) state_next = N_ROOT;
            N_ROOT: if (bit_reg[0]) state_next = N_LOAD;
            N_LOAD: state_next = N_DIV;
            N_DIV:
            begin
                if (div_cnt_reg == '0)
                    state_next = (comp_reg == 2'd3) ? N_DONE : N_LOAD;
            end
            N_DONE: state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        done = (state_reg == N_DONE);
        rsp  = rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= N_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
            begin
                sq_cnt_reg <= '0;
                acc_reg    <= UNIT_SQ;
            end
            N_MUL:
            begin
                x_reg <= mul_x;
                y_reg <= mul_y;
            end
            N_SQR:
            begin
                acc_reg    <= acc_reg + sq_term;
                sq_cnt_reg <= sq_cnt_reg + 2'd1;
                rem_reg    <= acc_reg + sq_term;
                root_reg   <= '0;
                bit_reg    <= SQ_W'(1) << (SQ_W - 1);
                comp_reg   <= '0;
            end
            N_ROOT:
            begin
                if (root_ge)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            N_LOAD:
            begin
                num_reg     <= num_load;
                den_reg     <= den_load;
                quo_reg     <= '0;
                div_cnt_reg <= DCNT_W'(QUO_W - 1);
            end
            N_DIV:
            begin
                if (div_ge)
                    num_reg <= num_reg - den_reg;
                quo_reg     <= q_new;
                den_reg     <= den_reg >> 1;
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                if (div_cnt_reg == '0)
                begin
                    unique case (comp_reg)
                        2'd0: rsp_reg.red   <= q_byte;
                        2'd1: rsp_reg.green <= q_byte;
                        2'd2: rsp_reg.blue  <= q_byte;
                        2'd3: rsp_reg.hbyte <= q_byte;
                    endcase
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/height_to_normal_map.sv =====
`timescale 1ns / 1ps
// Top level of the height-to-normal-map block: line stores, sequencer and
// output register. Uses htn_pkg and htn_norm.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes image_width
//   (0), image_height (1) and strength (2); cfg_ready is always high. Write it
//   only while the block is idle.
//   in channel takes one height pixel per transfer in raster order. Each pixel
//   releases up to three output pixels on the out channel: the pixel one row
//   above, and in the last row the pixel to the left and the final pixel.
//   run_last marks the last result of a pixel, frame_done the final pixel.
// Timing: one pixel at a time. A pixel first passes through line-store reads and
//   write-back, then each of its results passes through the shared normalizer
//   (squaring, square root, 4 byte divisions) and one output handshake.
// Reset: counters return to the frame start and registers to their defaults;
//   the line stores are not cleared, the first rows of a frame fill them.
// Stall: a result waits in the output register while out_ready is low; no new
//   pixel is taken until all results of the current pixel are transferred.
module height_to_normal_map (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [htn_pkg::IDX_W-1:0]   cfg_index,
    input  logic [htn_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [htn_pkg::PIX_W-1:0]   height_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [htn_pkg::COL_W-1:0]   out_col,
    output logic [htn_pkg::COL_W-1:0]   out_row,
    output logic [htn_pkg::BYTE_W-1:0]  normal_red,
    output logic [htn_pkg::BYTE_W-1:0]  normal_green,
    output logic [htn_pkg::BYTE_W-1:0]  normal_blue,
    output logic [htn_pkg::BYTE_W-1:0]  height_byte,
    output logic                        run_last,
    output logic                        frame_done
);
    import htn_pkg::*;

    htn_tstate_t state_reg, state_next;

    logic [SIZE_W-1:0] width_reg, height_reg, w_eff, h_eff;
    logic [STR_W-1:0]  strength_reg;
    logic [COL_W-1:0]  col_reg, row_reg, c_reg, r_reg;
    logic [PIX_W-1:0]  lp0_reg, lp1_reg, px_reg;
    logic              last_col_reg, last_row_reg;
    logic [PIX_W-1:0]  a_c_reg, b_c_reg, a_nx_reg, b_cm1_reg, a_cm2_reg;
    htn_slot_t         slot_reg [3];
    htn_slot_t         slot_next [3];
    logic [2:0]        slot_vld_reg, slot_vld_next;
    logic [1:0]        cur_reg, pick;

    logic [PIX_W-1:0]  ra_mem [MAX_SIZE];
    logic [PIX_W-1:0]  rb_mem [MAX_SIZE];
    logic [COL_W-1:0]  ra_addr, rb_addr;
    logic [PIX_W-1:0]  ra_q, rb_q;

    logic [SIZE_W:0]   col_p1, row_p1;
    logic              last_col, last_row, in_xfer, norm_start, norm_done;
    htn_rsp_t          norm_rsp;
    htn_slot_t         cur_slot;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RST;
            height_reg   <= HEIGHT_RST;
            strength_reg <= STRENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WIDTH:    width_reg    <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT:   height_reg   <= cfg_data[SIZE_W-1:0];
                REG_STRENGTH: strength_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Clamp the sizes and flag last column and row
    always_comb
    begin
        priority if (width_reg == '0)                 w_eff = SIZE_W'(1);
        else if (width_reg > SIZE_W'(MAX_SIZE))       w_eff = SIZE_W'(MAX_SIZE);
        else                                          w_eff = width_reg;
        priority if (height_reg == '0)                h_eff = SIZE_W'(1);
        else if (height_reg > SIZE_W'(MAX_SIZE))      h_eff = SIZE_W'(MAX_SIZE);
        else                                          h_eff = height_reg;
        col_p1   = (SIZE_W+1)'(col_reg) + (SIZE_W+1)'(1);
        row_p1   = (SIZE_W+1)'(row_reg) + (SIZE_W+1)'(1);
        last_col = col_p1 >= (SIZE_W+1)'(w_eff);
        last_row = row_p1 >= (SIZE_W+1)'(h_eff);
    end

    assign in_xfer = in_valid && in_ready;

    // Line store addresses: one read per store per cycle
    always_comb
    begin
        unique case (state_reg)
            T_RD0:
            begin
                ra_addr = c_reg + COL_W'(1);
                rb_addr = c_reg - COL_W'(1);
            end
            T_RD1:
            begin
                ra_addr = c_reg - COL_W'(2);
                rb_addr = c_reg;
            end
            T_IDLE:
            begin
                ra_addr = col_reg;
                rb_addr = col_reg;
            end
            default:
            begin
                ra_addr = c_reg;
                rb_addr = c_reg;
            end
        endcase
    end

    // Line stores; writes come only after all reads of the pixel are done
    always_ff @(posedge clk)
    begin
        ra_q <= ra_mem[ra_addr];
        rb_q <= rb_mem[rb_addr];
        if (state_reg == T_WB)
        begin
            ra_mem[c_reg] <= px_reg;
            rb_mem[c_reg] <= a_c_reg;
        end
    end

    // Build the result slots of the current pixel
    always_comb
    begin
        slot_vld_next[0] = (r_reg != '0);
        slot_vld_next[1] = last_row_reg && (c_reg != '0);
        slot_vld_next[2] = last_row_reg && last_col_reg;

        slot_next[0].col        = c_reg;
        slot_next[0].row        = r_reg - COL_W'(1);
        slot_next[0].nbr.left   = (c_reg != '0) ? lp0_reg : a_c_reg;
        slot_next[0].nbr.right  = a_nx_reg;
        slot_next[0].nbr.up     = (r_reg >= COL_W'(2)) ? b_c_reg : a_c_reg;
        slot_next[0].nbr.down   = px_reg;
        slot_next[0].nbr.center = a_c_reg;
        slot_next[0].run_last   = !slot_vld_next[1] && !slot_vld_next[2];
        slot_next[0].frame_done = 1'b0;

        slot_next[1].col        = c_reg - COL_W'(1);
        slot_next[1].row        = r_reg;
        slot_next[1].nbr.left   = (c_reg >= COL_W'(2)) ? a_cm2_reg : lp1_reg;
        slot_next[1].nbr.right  = px_reg;
        slot_next[1].nbr.up     = (r_reg != '0) ? b_cm1_reg : lp1_reg;
        slot_next[1].nbr.down   = lp1_reg;
        slot_next[1].nbr.center = lp1_reg;
        slot_next[1].run_last   = !slot_vld_next[2];
        slot_next[1].frame_done = 1'b0;

        slot_next[2].col        = c_reg;
        slot_next[2].row        = r_reg;
        slot_next[2].nbr.left   = (c_reg != '0) ? lp1_reg : px_reg;
        slot_next[2].nbr.right  = px_reg;
        slot_next[2].nbr.up     = (r_reg != '0) ? a_c_reg : px_reg;
        slot_next[2].nbr.down   = px_reg;
        slot_next[2].nbr.center = px_reg;
        slot_next[2].run_last   = 1'b1;
        slot_next[2].frame_done = 1'b1;
    end

    // Lowest pending slot goes first
    always_comb
    begin
        priority if (slot_vld_reg[0]) pick = 2'd0;
        else if (slot_vld_reg[1])     pick = 2'd1;
        else                          pick = 2'd2;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: if (in_valid) state_next = T_RD0;
            T_RD0:  state_next = T_RD1;
            T_RD1:  state_next = T_RD2;
            T_RD2:  state_next = T_WB;
            T_WB:   state_next = T_EMIT;
            T_EMIT: state_next = (slot_vld_reg != '0) ? T_CALC : T_IDLE;
            T_CALC: if (norm_done) state_next = T_OUT;
            T_OUT:  if (out_ready) state_next = T_EMIT;
            default: state_next = T_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_ready   = (state_reg == T_IDLE);
        out_valid  = (state_reg == T_OUT);
        norm_start = (state_reg == T_EMIT) && (slot_vld_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            lp0_reg      <= '0;
            lp1_reg      <= '0;
            slot_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == T_WB)
            begin
                // Advance the raster position and shift the left pixels
                slot_vld_reg <= slot_vld_next;
                lp0_reg      <= a_c_reg;
                lp1_reg      <= px_reg;
                if (last_col_reg)
                begin
                    col_reg <= '0;
                    row_reg <= last_row_reg ? '0 : r_reg + COL_W'(1);
                end
                else
                    col_reg <= c_reg + COL_W'(1);
            end
            else if (state_reg == T_OUT && out_ready)
                slot_vld_reg[cur_reg] <= 1'b0;
        end
    end

    // Capture the pixel and its neighbors
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg       <= height_sample;
            c_reg        <= col_reg;
            r_reg        <= row_reg;
            last_col_reg <= last_col;
            last_row_reg <= last_row;
        end
        if (state_reg == T_RD0)
        begin
            a_c_reg <= ra_q;
            b_c_reg <= rb_q;
        end
        if (state_reg == T_RD1)
        begin
            a_nx_reg  <= last_col_reg ? a_c_reg : ra_q;
            b_cm1_reg <= rb_q;
        end
        if (state_reg == T_RD2)
            a_cm2_reg <= ra_q;
        if (state_reg == T_WB)
            slot_reg <= slot_next;
        if (state_reg == T_EMIT)
            cur_reg <= pick;
    end

    assign cur_slot = (state_reg == T_EMIT) ? slot_reg[pick] : slot_reg[cur_reg];

    htn_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (norm_start),
        .req      (cur_slot.nbr),
        .strength (strength_reg),
        .done     (norm_done),
        .rsp      (norm_rsp)
    );

    // Result fields
    assign out_col      = cur_slot.col;
    assign out_row      = cur_slot.row;
    assign normal_red   = norm_rsp.red;
    assign normal_green = norm_rsp.green;
    assign normal_blue  = norm_rsp.blue;
    assign height_byte  = norm_rsp.hbyte;
    assign run_last     = cur_slot.run_last;
    assign frame_done   = cur_slot.frame_done;

    // Checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("pixel taken while a result is pending");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> run_last)
        else $error("frame end without run end");

    a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("second pixel taken before line store write-back");

endmodule

// ===== tb/sv/height_to_normal_map_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of height_to_normal_map: streams height frames,
// predicts every normal-map pixel and compares transfers on the out channel.
// Depends on htn_pkg and the height_to_normal_map RTL.
module height_to_normal_map_tb;
    import htn_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int LONG_HOLD      = 400;

    typedef struct packed {
        logic [8:0] col;
        logic [8:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] hbyte;
        logic       last;
        logic       done;
    } normal_px_t;

    // one directed pixel; a start row sets up a new frame first
    typedef struct {
        bit          start;
        int          fw;
        int          fh;
        int          fs;
        logic [15:0] smp;
        bit          typed;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  hbyte;
    } pixel_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = REG_WIDTH;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [PIX_W-1:0]   height_sample = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COL_W-1:0]   out_col;
    logic [COL_W-1:0]   out_row;
    logic [7:0]         normal_red;
    logic [7:0]         normal_green;
    logic [7:0]         normal_blue;
    logic [7:0]         height_byte;
    logic               run_last;
    logic               frame_done;

    // predictor state
    logic [15:0] line_above [512];
    logic [15:0] line_two_above [512];
    logic [15:0] prev_above;
    logic [15:0] prev_pixel;
    int          cur_col;
    int          cur_row;
    int          img_w = 512;
    int          img_h = 512;
    int          gain = 1152;

    normal_px_t  pending_normals [$];
    int          mismatches = 0;
    int          pixels_sent = 0;
    int          tx_idle_pct = 34;
    int          rx_stall_pct = 69;
    bit          hold_go = 1'b0;
    bit          hold_used = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    height_to_normal_map u_top (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [7:0] unit_to_byte(longint num, longint rt);
        longint unsigned n;
        longint unsigned b;
        n = 255 * (num + rt) + rt;
        b = n / (2 * rt);
        return (b > 255) ? 8'd255 : b[7:0];
    endfunction

    function automatic normal_px_t shade(int col, int row, int left, int right,
                                         int up, int down, int center);
        normal_px_t p;
        longint x;
        longint y;
        longint unsigned ux;
        longint unsigned uy;
        longint rt;
        x  = longint'(right - left) * gain;
        y  = longint'(down - up) * gain;
        ux = (x < 0) ? -x : x;
        uy = (y < 0) ? -y : y;
        rt = floor_root(ux * ux + uy * uy + 64'd281466386841600);
        p.col   = col[8:0];
        p.row   = row[8:0];
        p.red   = unit_to_byte(-x, rt);
        p.green = unit_to_byte(-y, rt);
        p.blue  = unit_to_byte(64'd16776960, rt);
        p.hbyte = 8'((center * 2 + 257) / 514);
        p.last  = 1'b0;
        p.done  = 1'b0;
        return p;
    endfunction

    function automatic int clamp_dim(int v);
        if (v < 1) return 1;
        if (v > 512) return 512;
        return v;
    endfunction

    // advance the predictor by one pixel and queue the normals it releases
    function automatic void take_pixel(logic [15:0] px, bit typed, logic [7:0] r8,
                                       logic [7:0] g8, logic [7:0] b8, logic [7:0] h8);
        normal_px_t outs [3];
        int w;
        int h;
        int c;
        int r;
        int k;
        int ac;
        int an;
        bit lc;
        bit lr;
        w  = clamp_dim(img_w);
        h  = clamp_dim(img_h);
        c  = cur_col;
        r  = cur_row;
        lc = (c + 1 >= w);
        lr = (r + 1 >= h);
        ac = line_above[c];
        an = lc ? ac : line_above[c + 1];
        k  = 0;
        // pixel above, now that its lower neighbor is here
        if (r >= 1)
        begin
            outs[k] = shade(c, r - 1, (c > 0) ? prev_above : ac, an,
                            (r >= 2) ? line_two_above[c] : ac, px, ac);
            k++;
        end
        // last row: pixel to the left
        if (lr && c >= 1)
        begin
            outs[k] = shade(c - 1, r, (c >= 2) ? line_above[c - 2] : prev_pixel, px,
                            (r >= 1) ? line_two_above[c - 1] : prev_pixel,
                            prev_pixel, prev_pixel);
            k++;
        end
        // final pixel of the frame
        if (lr && lc)
        begin
            outs[k] = shade(c, r, (c >= 1) ? prev_pixel : px, px,
                            (r >= 1) ? ac : px, px, px);
            outs[k].done = 1'b1;
            k++;
        end
        if (k > 0) outs[k - 1].last = 1'b1;
        for (int i = 0; i < k; i++)
        begin
            if (typed)
            begin
                outs[i].red   = r8;
                outs[i].green = g8;
                outs[i].blue  = b8;
                outs[i].hbyte = h8;
            end
            pending_normals.push_back(outs[i]);
        end
        line_two_above[c] = ac[15:0];
        line_above[c]     = px;
        prev_above        = ac[15:0];
        prev_pixel        = px;
        if (lc)
        begin
            cur_col = 0;
            cur_row = lr ? 0 : r + 1;
        end
        else
            cur_col = c + 1;
    endfunction

    // hold the write until the transfer; the caller drops cfg_valid
    task automatic write_reg(htn_reg_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_WIDTH:    img_w = value & 32'h3FF;
            REG_HEIGHT:   img_h = value & 32'h3FF;
            REG_STRENGTH: gain  = value & 32'hFFF;
            default: ;
        endcase
    endtask

    // drain every pending normal, let the block settle, then set up a frame
    task automatic start_frame(int fw, int fh, int fs);
        in_valid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_WIDTH, fw);
        write_reg(REG_HEIGHT, fh);
        write_reg(REG_STRENGTH, fs);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(logic [15:0] px, bit typed, logic [7:0] r8,
                              logic [7:0] g8, logic [7:0] b8, logic [7:0] h8);
        if (in_valid && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        height_sample <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        take_pixel(px, typed, r8, g8, b8, h8);
        pixels_sent++;
        // idle pattern follows the stimulus phase
        if (pixels_sent == 280)
        begin
            tx_idle_pct  = 69;
            rx_stall_pct = 34;
        end
        else if (pixels_sent == 560)
        begin
            tx_idle_pct  = 0;
            rx_stall_pct = 0;
        end
        if (pixels_sent == 120) hold_go = 1'b1;
    endtask

    function automatic logic [15:0] random_height(int mode, logic [15:0] prev);
        case (mode)
            0: return 16'($urandom());
            1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return prev + 16'($urandom_range(0, 4000)) - 16'd2000;
        endcase
    endfunction

    task automatic random_frame(int fw, int fh, int fs);
        logic [15:0] px;
        int mode;
        start_frame(fw, fh, fs);
        mode = $urandom_range(2);
        px   = 16'($urandom());
        for (int i = 0; i < clamp_dim(fw) * clamp_dim(fh); i++)
        begin
            px = random_height($urandom_range(3) == 0 ? $urandom_range(2) : mode, px);
            send_pixel(px, 1'b0, '0, '0, '0, '0);
        end
    endtask

    // ready pattern, with one long hold-off to back the block up
    always @(posedge clk)
    begin
        if (hold_go && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // compare each transfer with the oldest pending normal
    always @(posedge clk)
    begin
        normal_px_t got;
        normal_px_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_col, out_row, normal_red, normal_green, normal_blue,
                    height_byte, run_last, frame_done};
            if (pending_normals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel col=%0d row=%0d", out_col, out_row);
            end
            else
            begin
                want = pending_normals.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp col=%0d row=%0d rgb=%0d,%0d,%0d h=%0d l=%0b d=%0b / got col=%0d row=%0d rgb=%0d,%0d,%0d h=%0d l=%0b d=%0b",
                                 want.col, want.row, want.red, want.green, want.blue,
                                 want.hbyte, want.last, want.done, got.col, got.row,
                                 got.red, got.green, got.blue, got.hbyte, got.last,
                                 got.done);
                end
            end
        end
    end

    // end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        pixel_row_t plan [$];
        plan = '{
            // flat 2x2 frame at full height
            '{1, 2, 2, 1152, 16'hFFFF, 1, 8'd128, 8'd128, 8'd255, 8'd255},
            '{0, 0, 0, 0,    16'hFFFF, 1, 8'd128, 8'd128, 8'd255, 8'd255},
            '{0, 0, 0, 0,    16'hFFFF, 1, 8'd128, 8'd128, 8'd255, 8'd255},
            '{0, 0, 0, 0,    16'hFFFF, 1, 8'd128, 8'd128, 8'd255, 8'd255},
            // zero sizes act as one pixel, zero gain
            '{1, 0, 0, 0,    16'h0000, 1, 8'd128, 8'd128, 8'd255, 8'd0},
            // checkerboard at maximum gain
            '{1, 3, 3, 4095, 16'h0000, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0,    16'hFFFF, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0,    16'h0000, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0,    16'hFFFF, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0,    16'h0000, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0,    16'hFFFF, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0,    16'h0000, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0,    16'hFFFF, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0,    16'h0000, 0, 0, 0, 0, 0},
            // single column
            '{1, 1, 3, 2048, 16'h0000, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0,    16'd40000, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0,    16'hFFFF, 0, 0, 0, 0, 0},
            // single row, minimum nonzero gain
            '{1, 4, 1, 1,    16'h5555, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0,    16'hAAAA, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0,    16'h0001, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0,    16'hFFFE, 0, 0, 0, 0, 0}
        };
        cur_col    = 0;
        cur_row    = 0;
        prev_above = '0;
        prev_pixel = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (plan[i])
        begin
            if (plan[i].start) start_frame(plan[i].fw, plan[i].fh, plan[i].fs);
            send_pixel(plan[i].smp, plan[i].typed, plan[i].red, plan[i].green,
                       plan[i].blue, plan[i].hbyte);
        end

        // random frames, mostly small, with gain extremes now and then
        while (pixels_sent < 320)
        begin
            random_frame(($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8),
                         $urandom_range(1, 6),
                         ($urandom_range(5) == 0) ? ($urandom_range(1) ? 4095 : 0)
                                                  : $urandom_range(0, 4095));
        end
        // oversized width acts as the full line
        random_frame(1023, 1, $urandom_range(0, 4095));

        in_valid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_normals.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
